@@ hdl/assert_macros.svh @@
// Assertion macros shared by the modules of the navigation frame field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on aclk and disabled while aresetn is low.
`define UBXFX_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// Next-cycle implication, checked on aclk and disabled while aresetn is low.
`define UBXFX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

@@ hdl/ubxfx_pkg.sv @@
// Package with the frame codes, kinds and field layout of the navigation frame field extractor.
package ubxfx_pkg;

    localparam logic [7:0] SYNC_A      = 8'hB5;
    localparam logic [7:0] SYNC_B      = 8'h62;
    localparam logic [7:0] CLASS_SEC   = 8'h27;
    localparam logic [7:0] ID_UNIQID   = 8'h03;
    localparam logic [7:0] CLASS_NAV   = 8'h01;
    localparam logic [7:0] ID_TIMEUTC  = 8'h21;
    localparam logic [7:0] ID_PVT      = 8'h07;
    localparam logic [7:0] ID_POSLLH   = 8'h02;

    localparam logic [6:0] POS_HUNT  = 7'd0;
    localparam logic [6:0] POS_SYNC  = 7'd1;
    localparam logic [6:0] POS_CLASS = 7'd2;
    localparam logic [6:0] POS_ID    = 7'd3;
    localparam logic [6:0] POS_BODY  = 7'd4;

    localparam int NUM_FIELDS = 28;

    typedef enum logic [1:0] {
        KIND_UID = 2'd0,
        KIND_UTC = 2'd1,
        KIND_PVT = 2'd2,
        KIND_GEO = 2'd3
    } kind_e;

    typedef struct packed {
        logic [6:0] start;
        logic [2:0] len;
        logic [3:0] id;
        logic       sgn;
        kind_e      kind;
        logic       last;
    } field_desc_t;

    typedef struct packed {
        logic       hit;
        logic       field_end;
        logic [2:0] off;
        logic       sgn;
        logic       last;
        logic [3:0] id;
        logic       past_end;
    } lookup_t;

    localparam field_desc_t FIELD_TABLE [NUM_FIELDS] = '{
        '{7'd10, 3'd5, 4'd15, 1'b0, KIND_UID, 1'b1},
        '{7'd18, 3'd2, 4'd0,  1'b0, KIND_UTC, 1'b0},
        '{7'd20, 3'd1, 4'd1,  1'b0, KIND_UTC, 1'b0},
        '{7'd21, 3'd1, 4'd2,  1'b0, KIND_UTC, 1'b0},
        '{7'd22, 3'd1, 4'd3,  1'b0, KIND_UTC, 1'b0},
        '{7'd23, 3'd1, 4'd4,  1'b0, KIND_UTC, 1'b0},
        '{7'd24, 3'd1, 4'd5,  1'b0, KIND_UTC, 1'b1},
        '{7'd10, 3'd2, 4'd0,  1'b0, KIND_PVT, 1'b0},
        '{7'd12, 3'd1, 4'd1,  1'b0, KIND_PVT, 1'b0},
        '{7'd13, 3'd1, 4'd2,  1'b0, KIND_PVT, 1'b0},
        '{7'd14, 3'd1, 4'd3,  1'b0, KIND_PVT, 1'b0},
        '{7'd15, 3'd1, 4'd4,  1'b0, KIND_PVT, 1'b0},
        '{7'd16, 3'd1, 4'd5,  1'b0, KIND_PVT, 1'b0},
        '{7'd26, 3'd1, 4'd6,  1'b0, KIND_PVT, 1'b0},
        '{7'd30, 3'd4, 4'd7,  1'b1, KIND_PVT, 1'b0},
        '{7'd34, 3'd4, 4'd8,  1'b1, KIND_PVT, 1'b0},
        '{7'd38, 3'd4, 4'd9,  1'b1, KIND_PVT, 1'b0},
        '{7'd42, 3'd4, 4'd10, 1'b1, KIND_PVT, 1'b0},
        '{7'd46, 3'd4, 4'd11, 1'b0, KIND_PVT, 1'b0},
        '{7'd50, 3'd4, 4'd12, 1'b0, KIND_PVT, 1'b0},
        '{7'd66, 3'd4, 4'd13, 1'b1, KIND_PVT, 1'b0},
        '{7'd70, 3'd4, 4'd14, 1'b1, KIND_PVT, 1'b1},
        '{7'd10, 3'd4, 4'd7,  1'b1, KIND_GEO, 1'b0},
        '{7'd14, 3'd4, 4'd8,  1'b1, KIND_GEO, 1'b0},
        '{7'd18, 3'd4, 4'd9,  1'b1, KIND_GEO, 1'b0},
        '{7'd22, 3'd4, 4'd10, 1'b1, KIND_GEO, 1'b0},
        '{7'd26, 3'd4, 4'd11, 1'b0, KIND_GEO, 1'b0},
        '{7'd30, 3'd4, 4'd12, 1'b0, KIND_GEO, 1'b1}
    };

    // Offset of the last byte used by each kind.
    localparam logic [6:0] KIND_END [4] = '{7'd14, 7'd24, 7'd73, 7'd33};

    localparam logic [6:0] POS_MAX = 7'd73;

endpackage

@@ hdl/ubxfx_field_lookup.sv @@
// Field layout lookup: maps a message kind and frame offset to the field that byte belongs to.
module ubxfx_field_lookup
    import ubxfx_pkg::*;
(
    input  kind_e      kind,
    input  logic [6:0] pos,
    output lookup_t    lk
);

    logic [7:0] stop;
    logic [6:0] rel;

    always_comb begin
        lk          = '0;
        lk.past_end = (pos > KIND_END[kind]);
        for (int i = 0; i < NUM_FIELDS; i++) begin
            stop = {1'b0, FIELD_TABLE[i].start} + {5'b0, FIELD_TABLE[i].len};
            rel  = pos - FIELD_TABLE[i].start;
            if (FIELD_TABLE[i].kind == kind && pos >= FIELD_TABLE[i].start
                    && {1'b0, pos} < stop) begin
                lk.hit       = 1'b1;
                lk.off       = rel[2:0];
                lk.field_end = (rel[2:0] == FIELD_TABLE[i].len - 3'd1);
                lk.sgn       = FIELD_TABLE[i].sgn;
                lk.last      = FIELD_TABLE[i].last;
                lk.id        = FIELD_TABLE[i].id;
            end
        end
    end

endmodule

@@ hdl/ubxfx_core.sv @@
// Frame tracker, field assembler and result register of the navigation frame field extractor.
module ubxfx_core
    import ubxfx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               byte_valid,
    input  logic [7:0]         byte_data,
    output logic               byte_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_field_id,
    output logic signed [40:0] m_field_value,
    output logic [1:0]         m_message_kind,
    output logic               m_last_of_message
);

`include "assert_macros.svh"

    logic [6:0]  pos_reg, pos_next;
    kind_e       kind_reg, kind_next;
    logic [7:0]  class_reg, class_next;
    logic [39:0] acc_reg, acc_next;

    logic               m_valid_reg, m_valid_next;
    logic [3:0]         id_reg, id_next;
    logic signed [40:0] value_reg, value_next;
    logic [1:0]         mkind_reg, mkind_next;
    logic               mlast_reg, mlast_next;

    lookup_t     lk;
    logic        step;
    logic        emit;
    logic [39:0] acc_base;
    logic [39:0] acc_new;

    ubxfx_field_lookup u_lookup (
        .kind (kind_reg),
        .pos  (pos_reg),
        .lk   (lk)
    );

    assign byte_ready = !m_valid_reg || m_ready;
    assign step       = byte_valid && byte_ready;
    assign acc_base   = (lk.off == 3'd0) ? 40'd0 : acc_reg;
    assign acc_new    = acc_base | ({32'd0, byte_data} << {lk.off, 3'b000});
    assign emit       = step && pos_reg >= POS_BODY && !lk.past_end && lk.hit && lk.field_end;

    always_comb begin
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        class_next = class_reg;
        acc_next   = acc_reg;
        if (step) begin
            if (pos_reg == POS_HUNT) begin
                pos_next = (byte_data == SYNC_A) ? POS_SYNC : POS_HUNT;
            end else if (pos_reg == POS_SYNC) begin
                if (byte_data == SYNC_B) begin
                    pos_next = POS_CLASS;
                end else if (byte_data == SYNC_A) begin
                    pos_next = POS_SYNC;
                end else begin
                    pos_next = POS_HUNT;
                end
            end else if (pos_reg == POS_CLASS) begin
                class_next = byte_data;
                pos_next   = POS_ID;
            end else if (pos_reg == POS_ID) begin
                pos_next = POS_BODY;
                if (class_reg == CLASS_SEC && byte_data == ID_UNIQID) begin
                    kind_next = KIND_UID;
                end else if (class_reg == CLASS_NAV && byte_data == ID_TIMEUTC) begin
                    kind_next = KIND_UTC;
                end else if (class_reg == CLASS_NAV && byte_data == ID_PVT) begin
                    kind_next = KIND_PVT;
                end else if (class_reg == CLASS_NAV && byte_data == ID_POSLLH) begin
                    kind_next = KIND_GEO;
                end else begin
                    pos_next = POS_HUNT;
                end
            end else if (lk.past_end) begin
                pos_next = POS_HUNT;
            end else begin
                pos_next = pos_reg + 7'd1;
                if (lk.hit) begin
                    acc_next = acc_new;
                    if (lk.field_end && lk.last) begin
                        pos_next = POS_HUNT;
                    end
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        id_next      = id_reg;
        value_next   = value_reg;
        mkind_next   = mkind_reg;
        mlast_next   = mlast_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            id_next      = lk.id;
            mkind_next   = kind_reg;
            mlast_next   = lk.last;
            if (lk.sgn) begin
                value_next = {{9{acc_new[31]}}, acc_new[31:0]};
            end else begin
                value_next = {1'b0, acc_new};
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HUNT;
            kind_reg    <= KIND_UID;
            class_reg   <= 8'd0;
            acc_reg     <= 40'd0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            class_reg   <= class_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        value_reg <= value_next;
        mkind_reg <= mkind_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_field_id        = id_reg;
    assign m_field_value     = value_reg;
    assign m_message_kind    = mkind_reg;
    assign m_last_of_message = mlast_reg;

    `UBXFX_ASSERT(a_pos_in_range, 1'b1, pos_reg <= POS_MAX)
    `UBXFX_ASSERT_NEXT(a_kind_held_in_body, pos_reg > POS_ID, $stable(kind_reg))
    `UBXFX_ASSERT_NEXT(a_last_resumes_hunt, emit && lk.last, pos_reg == POS_HUNT)

endmodule

@@ hdl/ubx_nav_message_field_extractor.sv @@
// Top level of the navigation frame field extractor: input register and field extraction core.
//
// The block accepts one received byte per cycle and emits at most one extracted field per
// byte. A byte is registered in the input register and then passes through the frame
// tracker and field assembler into the result register. The sustained rate is one byte per
// cycle; the only throttle is a held result, which stalls the input register while m_ready
// stays low.
module ubx_nav_message_field_extractor
    import ubxfx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_field_id,
    output logic signed [40:0] m_field_value,
    output logic [1:0]         m_message_kind,
    output logic               m_last_of_message
);

`include "assert_macros.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       core_ready;

    assign s_ready = !in_valid_reg || core_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    ubxfx_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .byte_valid        (in_valid_reg),
        .byte_data         (in_byte_reg),
        .byte_ready        (core_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_field_id        (m_field_id),
        .m_field_value     (m_field_value),
        .m_message_kind    (m_message_kind),
        .m_last_of_message (m_last_of_message)
    );

    `UBXFX_ASSERT_NEXT(a_held_byte_kept, in_valid_reg && !core_ready,
                       in_valid_reg && $stable(in_byte_reg))

endmodule

@@ sim/tb_ubx_nav_message_field_extractor.sv @@
// Self-checking testbench for the navigation frame field extractor: directed table, random frames.
module tb_ubx_nav_message_field_extractor;
    import ubxfx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [3:0] {
        F_YEAR = 4'd0, F_MONTH = 4'd1, F_DAY = 4'd2, F_HOUR = 4'd3,
        F_MINUTE = 4'd4, F_SECOND = 4'd5, F_FIX = 4'd6, F_LON = 4'd7,
        F_LAT = 4'd8, F_HEIGHT = 4'd9, F_MSL = 4'd10, F_HACC = 4'd11,
        F_VACC = 4'd12, F_SPEED = 4'd13, F_HEADING = 4'd14, F_UID = 4'd15
    } field_e;

    typedef struct packed {
        logic [6:0] start;
        logic [2:0] len;
        logic [3:0] id;
        logic       sgn;
    } slot_t;

    typedef struct packed {
        logic [3:0]         id;
        logic signed [40:0] value;
        kind_e              kind;
        logic               last;
    } field_out_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        field_out_t exp;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_field_id;
    logic signed [40:0] m_field_value;
    logic [1:0]         m_message_kind;
    logic               m_last_of_message;

    ubx_nav_message_field_extractor dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_field_id        (m_field_id),
        .m_field_value     (m_field_value),
        .m_message_kind    (m_message_kind),
        .m_last_of_message (m_last_of_message)
    );

    always #5 aclk = ~aclk;

    logic [6:0]  frame_pos = POS_HUNT;
    kind_e       kind_held = KIND_UID;
    logic [7:0]  class_held = 8'h00;
    logic [39:0] field_acc = 40'd0;

    field_out_t  pending_fields[$];
    row_t        dir_table[$];
    logic        cur_typed = 1'b0;
    field_out_t  cur_exp = '0;
    field_out_t  want;
    field_out_t  guess;
    bit          hit;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          errors = 0;
    int          fields_checked = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    int          kind_frames[4] = '{0, 0, 0, 0};

    function automatic slot_t slot_of(input int idx);
        case (idx)
            0:  return {7'd10, 3'd5, F_UID, 1'b0};
            1:  return {7'd18, 3'd2, F_YEAR, 1'b0};
            2:  return {7'd20, 3'd1, F_MONTH, 1'b0};
            3:  return {7'd21, 3'd1, F_DAY, 1'b0};
            4:  return {7'd22, 3'd1, F_HOUR, 1'b0};
            5:  return {7'd23, 3'd1, F_MINUTE, 1'b0};
            6:  return {7'd24, 3'd1, F_SECOND, 1'b0};
            7:  return {7'd10, 3'd2, F_YEAR, 1'b0};
            8:  return {7'd12, 3'd1, F_MONTH, 1'b0};
            9:  return {7'd13, 3'd1, F_DAY, 1'b0};
            10: return {7'd14, 3'd1, F_HOUR, 1'b0};
            11: return {7'd15, 3'd1, F_MINUTE, 1'b0};
            12: return {7'd16, 3'd1, F_SECOND, 1'b0};
            13: return {7'd26, 3'd1, F_FIX, 1'b0};
            14: return {7'd30, 3'd4, F_LON, 1'b1};
            15: return {7'd34, 3'd4, F_LAT, 1'b1};
            16: return {7'd38, 3'd4, F_HEIGHT, 1'b1};
            17: return {7'd42, 3'd4, F_MSL, 1'b1};
            18: return {7'd46, 3'd4, F_HACC, 1'b0};
            19: return {7'd50, 3'd4, F_VACC, 1'b0};
            20: return {7'd66, 3'd4, F_SPEED, 1'b1};
            21: return {7'd70, 3'd4, F_HEADING, 1'b1};
            22: return {7'd10, 3'd4, F_LON, 1'b1};
            23: return {7'd14, 3'd4, F_LAT, 1'b1};
            24: return {7'd18, 3'd4, F_HEIGHT, 1'b1};
            25: return {7'd22, 3'd4, F_MSL, 1'b1};
            26: return {7'd26, 3'd4, F_HACC, 1'b0};
            default: return {7'd30, 3'd4, F_VACC, 1'b0};
        endcase
    endfunction

    function automatic int first_slot(input kind_e k);
        case (k)
            KIND_UID: return 0;
            KIND_UTC: return 1;
            KIND_PVT: return 7;
            default:  return 22;
        endcase
    endfunction

    function automatic int slot_count(input kind_e k);
        case (k)
            KIND_UID: return 1;
            KIND_UTC: return 6;
            KIND_PVT: return 15;
            default:  return 6;
        endcase
    endfunction

    function automatic int last_offset(input kind_e k);
        slot_t s;
        s = slot_of(first_slot(k) + slot_count(k) - 1);
        return int'(s.start) + int'(s.len) - 1;
    endfunction

    // Advances the frame tracker by one byte; returns 1 when a field completes.
    function automatic bit predict_field(input logic [7:0] b, output field_out_t r);
        int    base;
        int    cnt;
        int    pos;
        int    st;
        int    ln;
        int    off;
        int    i;
        bit    found;
        bit    done;
        slot_t s;
        done = 1'b0;
        found = 1'b0;
        r = '0;
        pos = int'(frame_pos);
        if (frame_pos == POS_HUNT) begin
            frame_pos = (b == SYNC_A) ? POS_SYNC : POS_HUNT;
        end else if (frame_pos == POS_SYNC) begin
            if (b == SYNC_B) frame_pos = POS_CLASS;
            else if (b == SYNC_A) frame_pos = POS_SYNC;
            else frame_pos = POS_HUNT;
        end else if (frame_pos == POS_CLASS) begin
            class_held = b;
            frame_pos = POS_ID;
        end else if (frame_pos == POS_ID) begin
            frame_pos = POS_BODY;
            if (class_held == CLASS_SEC && b == ID_UNIQID) kind_held = KIND_UID;
            else if (class_held == CLASS_NAV && b == ID_TIMEUTC) kind_held = KIND_UTC;
            else if (class_held == CLASS_NAV && b == ID_PVT) kind_held = KIND_PVT;
            else if (class_held == CLASS_NAV && b == ID_POSLLH) kind_held = KIND_GEO;
            else frame_pos = POS_HUNT;
        end else if (pos > last_offset(kind_held)) begin
            frame_pos = POS_HUNT;
        end else begin
            base = first_slot(kind_held);
            cnt = slot_count(kind_held);
            for (i = 0; i < cnt && !found; i++) begin
                s = slot_of(base + i);
                st = int'(s.start);
                ln = int'(s.len);
                if (pos >= st && pos < st + ln) begin
                    found = 1'b1;
                    off = pos - st;
                    if (off == 0) field_acc = 40'd0;
                    field_acc = field_acc | ({32'd0, b} << (8 * off));
                    if (off == ln - 1) begin
                        done = 1'b1;
                        r.id = s.id;
                        r.value = s.sgn ? {{9{field_acc[31]}}, field_acc[31:0]}
                                        : {1'b0, field_acc};
                        r.kind = kind_held;
                        r.last = (i == cnt - 1);
                        frame_pos = r.last ? POS_HUNT : 7'(pos + 1);
                    end
                end
            end
            if (!done) frame_pos = 7'(pos + 1);
        end
        return done;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            4: return SYNC_A;
            5: return SYNC_B;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic [7:0] b, input logic typed, input field_out_t e);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        cur_typed <= typed;
        cur_exp <= e;
        do @(posedge aclk); while (!(s_valid && s_ready));
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_header(input kind_e k);
        send_item(SYNC_A, 1'b0, '0);
        send_item(SYNC_B, 1'b0, '0);
        case (k)
            KIND_UID: begin
                send_item(CLASS_SEC, 1'b0, '0);
                send_item(ID_UNIQID, 1'b0, '0);
            end
            KIND_UTC: begin
                send_item(CLASS_NAV, 1'b0, '0);
                send_item(ID_TIMEUTC, 1'b0, '0);
            end
            KIND_PVT: begin
                send_item(CLASS_NAV, 1'b0, '0);
                send_item(ID_PVT, 1'b0, '0);
            end
            default: begin
                send_item(CLASS_NAV, 1'b0, '0);
                send_item(ID_POSLLH, 1'b0, '0);
            end
        endcase
    endtask

    task automatic send_frame(input kind_e k);
        int n;
        kind_frames[k]++;
        send_header(k);
        for (n = int'(POS_BODY); n <= last_offset(k); n++) send_item(data_byte(), 1'b0, '0);
    endtask

    task automatic send_broken();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                send_item(SYNC_A, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            1: begin
                repeat ($urandom_range(1, 3)) send_item(SYNC_A, 1'b0, '0);
                send_item(SYNC_B, 1'b0, '0);
                send_item(CLASS_NAV, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            2: begin
                send_item(SYNC_A, 1'b0, '0);
                send_item(SYNC_B, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            default: begin
                send_header(kind_e'($urandom_range(0, 3)));
                n = $urandom_range(1, 10);
                repeat (n) send_item(data_byte(), 1'b0, '0);
            end
        endcase
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d fields outstanding.",
                     cycle_count, pending_fields.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                fields_checked++;
                if (pending_fields.size() == 0) begin
                    $error("Unexpected transaction: field_id %0d value %0d",
                           m_field_id, m_field_value);
                    errors++;
                end else begin
                    want = pending_fields.pop_front();
                    if (m_field_id !== want.id) begin
                        $error("field_id: expected %0d, actual %0d", want.id, m_field_id);
                        errors++;
                    end
                    if (m_field_value !== want.value) begin
                        $error("field_value: expected %0d, actual %0d",
                               want.value, m_field_value);
                        errors++;
                    end
                    if (m_message_kind !== want.kind) begin
                        $error("message_kind: expected %0d, actual %0d",
                               want.kind, m_message_kind);
                        errors++;
                    end
                    if (m_last_of_message !== want.last) begin
                        $error("last_of_message: expected %0d, actual %0d",
                               want.last, m_last_of_message);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                hit = predict_field(s_rx_byte, guess);
                if (cur_typed) pending_fields.push_back(cur_exp);
                else if (hit) pending_fields.push_back(guess);
            end
        end
    end

    initial begin
        int dir_count;
        int r;
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({8'h00, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});
        dir_table.push_back({CLASS_SEC, 1'b0, 48'd0});
        dir_table.push_back({ID_UNIQID, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});
        dir_table.push_back({8'h00, 1'b0, 48'd0});
        dir_table.push_back({8'hFF, 1'b0, 48'd0});
        repeat (4) dir_table.push_back({8'hFF, 1'b0, 48'd0});
        dir_table.push_back({8'hFF, 1'b1, F_UID, 41'h0FF_FFFF_FFFF, KIND_UID, 1'b1});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});
        dir_table.push_back({CLASS_SEC, 1'b0, 48'd0});
        dir_table.push_back({8'h04, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});
        dir_table.push_back({CLASS_NAV, 1'b0, 48'd0});
        dir_table.push_back({SYNC_A, 1'b0, 48'd0});
        dir_table.push_back({SYNC_B, 1'b0, 48'd0});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_table[i]) send_item(dir_table[i].b, dir_table[i].typed, dir_table[i].exp);
        dir_count = bytes_sent;

        while (bytes_sent < dir_count + BYTE_TARGET) begin
            no_idle = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(kind_e'($urandom_range(0, 3)));
            end else if (r < 85) begin
                send_broken();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(($urandom_range(0, 3) == 0) ? SYNC_A : 8'($urandom_range(0, 255)),
                              1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_fields.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes (%0d directed); frames uid/utc/pvt/geo: %0d/%0d/%0d/%0d.",
                 bytes_sent, dir_count, kind_frames[KIND_UID], kind_frames[KIND_UTC],
                 kind_frames[KIND_PVT], kind_frames[KIND_GEO]);
        $display("Compared %0d extracted fields, %0d mismatches.", fields_checked, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ubxfx_pkg.sv
hdl/ubxfx_field_lookup.sv
hdl/ubxfx_core.sv
hdl/ubx_nav_message_field_extractor.sv
sim/tb_ubx_nav_message_field_extractor.sv
